[design/sra_pkg.sv]
// ----------------------------------------------------------------------------
// sra_pkg
// Shared widths, constants and the work descriptor of the row analysis block.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int SMP_W               = 16;
  localparam int IDX_W               = 11;
  localparam int LO_W                = 13;
  localparam int HI_W                = 15;
  localparam int TAPS                = 5;
  localparam int MAX_ROW_LENGTH_DEF  = 4096;
  localparam int QUEUE_DEPTH         = 4;

  // one accepted sample that yields work: the five-sample window x[p-4..p]
  // (smp[0] oldest) and what the back end has to produce from it
  typedef struct packed {
    logic [TAPS-1:0][SMP_W-1:0] smp;
    logic                       has_mid;    // result for j = p-2
    logic                       has_end;    // closing result of the row
    logic                       end_odd;    // row has even length, j = p-1
    logic                       left_edge;  // j = 0, mirror about x[0]
    logic                       is_short;   // row of one or two samples
    logic [IDX_W-1:0]           idx_mid;
    logic [IDX_W-1:0]           idx_end;
  } desc_t;

endpackage

[design/sra_front.sv]
// ----------------------------------------------------------------------------
// sra_front
// Takes samples, keeps the window and row position, and queues work items.
// ----------------------------------------------------------------------------
module sra_front #(
  parameter int MAX_ROW_LENGTH = sra_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sra_pkg::SMP_W-1:0]  in_sample,
  input  logic                       in_last_in_row,
  input  logic                       fifo_full,
  output logic                       push,
  output sra_pkg::desc_t             push_desc
);

  localparam int PW = $clog2(MAX_ROW_LENGTH);
  localparam int EW = (PW > sra_pkg::IDX_W + 1) ? PW : sra_pkg::IDX_W + 1;

  logic [PW-1:0]                    pos_r, pos_nxt;
  logic [3:0][sra_pkg::SMP_W-1:0]   win_r, win_nxt;
  logic                             acc;
  logic                             last;
  logic                             early;
  logic                             even;
  logic [EW-1:0]                    pos_ext;
  logic [sra_pkg::IDX_W-1:0]        half;

  assign in_ready = !fifo_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    // an overlong row is cut at the last position that fits
    last    = in_last_in_row || (pos_r == PW'(MAX_ROW_LENGTH - 1));
    early   = (pos_r < PW'(2));
    even    = !pos_r[0];
    pos_ext = EW'(pos_r);
    half    = pos_ext[sra_pkg::IDX_W:1];

    push_desc.smp       = {in_sample, win_r};
    push_desc.has_mid   = even && !early;
    push_desc.has_end   = last;
    push_desc.end_odd   = pos_r[0];
    push_desc.left_edge = (pos_r == PW'(2));
    push_desc.is_short  = last && early;
    push_desc.idx_mid   = half - sra_pkg::IDX_W'(1);
    push_desc.idx_end   = half;

    push    = acc && (last || (even && !early));
    pos_nxt = pos_r;
    win_nxt = win_r;
    if (acc) begin
      win_nxt = {in_sample, win_r[3:1]};
      pos_nxt = last ? '0 : pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      win_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      win_r <= win_nxt;
    end
  end

endmodule

[design/sra_fifo.sv]
// ----------------------------------------------------------------------------
// sra_fifo
// Small queue of work items between the front and the back end.
// ----------------------------------------------------------------------------
module sra_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sra_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sra_pkg::desc_t head
);

  localparam int DEPTH = sra_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  sra_pkg::desc_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_pop;

  assign full       = (cnt_r == (AW+1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

[design/sra_back.sv]
// ----------------------------------------------------------------------------
// sra_back
// Computes the low and high bands for each queued item into the output register.
// ----------------------------------------------------------------------------
module sra_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  sra_pkg::desc_t                   head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sra_pkg::IDX_W-1:0]        out_index,
  output logic signed [sra_pkg::LO_W-1:0]  out_low_band,
  output logic signed [sra_pkg::HI_W-1:0]  out_high_band,
  output logic                             out_row_done,
  output logic                             out_short_row
);

  localparam int W = sra_pkg::SMP_W;

  logic                         phase_r, phase_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sra_pkg::IDX_W-1:0]    out_index_r;
  logic [sra_pkg::LO_W-1:0]     out_low_band_r;
  logic [sra_pkg::HI_W-1:0]     out_high_band_r;
  logic                         out_row_done_r;
  logic                         out_short_row_r;

  logic                         want_end;
  logic                         fire;
  logic                         split;
  logic [W-1:0]                 ta, tb, tc, td, te;
  logic [W-1:0]                 lo_sum, lo_adj, hi_sum, hi_adj;

  always_comb begin
    want_end = !head.has_mid || phase_r;
    // pick the five taps, mirrored at the row edges
    if (!want_end) begin
      ta = head.left_edge ? head.smp[4] : head.smp[0];
      tb = head.left_edge ? head.smp[3] : head.smp[1];
      tc = head.smp[2];
      td = head.smp[3];
      te = head.smp[4];
    end else if (head.end_odd) begin
      ta = head.smp[1];
      tb = head.smp[2];
      tc = head.smp[3];
      td = head.smp[4];
      te = head.smp[3];
    end else begin
      ta = head.smp[2];
      tb = head.smp[3];
      tc = head.smp[4];
      td = head.smp[3];
      te = head.smp[2];
    end

    // 16-bit wrapping sums, then divide truncating toward zero
    lo_sum = {tb[W-2:0], 1'b0} + {tc[W-3:0], 2'b00} + {tc[W-2:0], 1'b0}
           + {td[W-2:0], 1'b0} - ta - te;
    lo_adj = lo_sum + (lo_sum[W-1] ? W'(7) : W'(0));
    hi_sum = {tb[W-2:0], 1'b0} - ta - tc;
    hi_adj = hi_sum + W'(hi_sum[W-1]);

    fire          = head_valid && (!out_valid_r || out_ready);
    split         = head.has_mid && head.has_end && !phase_r;
    pop           = fire && !split;
    phase_nxt     = fire ? split : phase_r;
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_index_r     <= want_end ? head.idx_end : head.idx_mid;
      out_low_band_r  <= head.is_short ? '0 : lo_adj[W-1:3];
      out_high_band_r <= head.is_short ? '0 : hi_adj[W-1:1];
      out_row_done_r  <= want_end;
      out_short_row_r <= head.is_short;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_low_band  = out_low_band_r;
  assign out_high_band = out_high_band_r;
  assign out_row_done  = out_row_done_r;
  assign out_short_row = out_short_row_r;

`ifndef SYNTHESIS
  a_phase_has_both: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid && head.has_mid && head.has_end)
    else $error("second result pending without a two-result item");

  a_short_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_short_row_r |->
      out_row_done_r && (out_low_band_r == '0) && (out_high_band_r == '0))
    else $error("short row result malformed");
`endif

endmodule

[design/subband_row_analysis_top.sv]
// ----------------------------------------------------------------------------
// subband_row_analysis_top
// Two-channel subband analysis of one row, streamed one sample at a time.
// ----------------------------------------------------------------------------
// Samples are accepted at one per cycle whenever the four-entry work queue
// has room; the first result that a sample completes passes the work queue
// and the output register, and a second result of the same sample follows
// it. The back end writes one result per cycle into the output register
// while out_ready allows, so an item that closes an odd-length row (two
// results) holds the queue head until both are written; since a row yields
// about one result per two samples, the queue absorbs this and the input
// rate stays at one sample per cycle as long as out_ready is not held low.
// Row edges are mirrored about the edge sample, rows of one or two samples
// give a single flagged result, and a row is cut after MAX_ROW_LENGTH samples.
module subband_row_analysis_top #(
  parameter int MAX_ROW_LENGTH = sra_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sra_pkg::SMP_W-1:0] in_sample,
  input  logic                             in_last_in_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sra_pkg::IDX_W-1:0]        out_index,
  output logic signed [sra_pkg::LO_W-1:0]  out_low_band,
  output logic signed [sra_pkg::HI_W-1:0]  out_high_band,
  output logic                             out_row_done,
  output logic                             out_short_row
);

  logic           push;
  logic           fifo_full;
  logic           pop;
  logic           head_valid;
  sra_pkg::desc_t push_desc;
  sra_pkg::desc_t head;

  sra_front #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_in_row (in_last_in_row),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_desc      (push_desc)
  );

  sra_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sra_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_index     (out_index),
    .out_low_band  (out_low_band),
    .out_high_band (out_high_band),
    .out_row_done  (out_row_done),
    .out_short_row (out_short_row)
  );

endmodule

[sim/tb_subband_row_analysis_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subband_row_analysis_top
// Streams rows of signed samples into the row analysis block and checks every
// low/high band result against a cycle-free model of the five-tap filter bank
// with mirrored row edges. Covers short rows, edge rows and random rows under
// several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_subband_row_analysis_top;

  localparam int SMP_W   = sra_pkg::SMP_W;
  localparam int IDX_W   = sra_pkg::IDX_W;
  localparam int LO_W    = sra_pkg::LO_W;
  localparam int HI_W    = sra_pkg::HI_W;
  localparam int ROW_MAX = sra_pkg::MAX_ROW_LENGTH_DEF;

  typedef struct {
    logic [IDX_W-1:0]       idx;
    logic signed [LO_W-1:0] lo;
    logic signed [HI_W-1:0] hi;
    logic                   done;
    logic                   is_short;
  } band_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic signed [SMP_W-1:0] in_sample      = '0;
  logic                    in_last_in_row = 1'b0;
  logic                    out_ready      = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [IDX_W-1:0]        out_index;
  logic signed [LO_W-1:0]  out_low_band;
  logic signed [HI_W-1:0]  out_high_band;
  logic                    out_row_done;
  logic                    out_short_row;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int mismatch_cnt = 0;

  band_t band_q[$];

  // model state: last four samples (oldest first) and position in the row
  logic signed [SMP_W-1:0] row_win[4];
  int                      row_pos = 0;
  logic signed [SMP_W-1:0] taps_now[5];

  subband_row_analysis_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_in_row (in_last_in_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index      (out_index),
    .out_low_band   (out_low_band),
    .out_high_band  (out_high_band),
    .out_row_done   (out_row_done),
    .out_short_row  (out_short_row)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // x[k] with whole-sample mirroring about both row edges
  function automatic int mirror_tap(int p, bit last, int k);
    int i;
    if (k < 0) k = -k;
    if (last && k > p) k = 2 * p - k;
    i = k - p + 4;
    if (i < 0) i = 0;
    if (i > 4) i = 4;
    return int'(taps_now[i]);
  endfunction

  task automatic push_band(int p, bit last, int j, bit done);
    int a, b, c, d, e, lo_q, hi_q;
    logic signed [SMP_W-1:0] lo_w, hi_w;
    band_t nb;
    a = mirror_tap(p, last, j - 2);
    b = mirror_tap(p, last, j - 1);
    c = mirror_tap(p, last, j);
    d = mirror_tap(p, last, j + 1);
    e = mirror_tap(p, last, j + 2);
    // sums wrap at 16 bits, then divide truncating toward zero
    lo_w = SMP_W'(-a + 2 * b + 6 * c + 2 * d - e);
    hi_w = SMP_W'(-a + 2 * b - c);
    lo_q = int'(lo_w) / 8;
    hi_q = int'(hi_w) / 2;
    nb.idx      = IDX_W'(j >> 1);
    nb.lo       = LO_W'(lo_q);
    nb.hi       = HI_W'(hi_q);
    nb.done     = done;
    nb.is_short = 1'b0;
    band_q.push_back(nb);
  endtask

  task automatic predict_row_step(logic signed [SMP_W-1:0] x, logic last_flag);
    int p;
    bit last;
    band_t nb;
    p    = row_pos;
    last = last_flag || (row_pos >= ROW_MAX - 1);
    for (int i = 0; i < 4; i++) taps_now[i] = row_win[i];
    taps_now[4] = x;
    if (last && p < 2) begin
      nb.idx      = '0;
      nb.lo       = '0;
      nb.hi       = '0;
      nb.done     = 1'b1;
      nb.is_short = 1'b1;
      band_q.push_back(nb);
    end else begin
      if (p % 2 == 0 && p >= 2) push_band(p, last, p - 2, 1'b0);
      if (last) push_band(p, last, (p % 2 == 0) ? p : p - 1, 1'b1);
    end
    for (int i = 0; i < 3; i++) row_win[i] = row_win[i + 1];
    row_win[3] = x;
    row_pos    = last ? 0 : row_pos + 1;
  endtask

  // valid stays high between back-to-back items; lowered only for idle cycles
  task automatic send_sample(logic signed [SMP_W-1:0] s, logic last_flag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_in_row <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_row_step(s, last_flag);
  endtask

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : chk_result
    band_t want;
    if (rst_n && out_valid && out_ready) begin
      if (band_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result idx=%0d lo=%0d hi=%0d done=%b short=%b",
                                out_index, out_low_band, out_high_band, out_row_done,
                                out_short_row));
      end else begin
        want = band_q.pop_front();
        if (out_index !== want.idx || out_low_band !== want.lo ||
            out_high_band !== want.hi || out_row_done !== want.done ||
            out_short_row !== want.is_short) begin
          note_mismatch($sformatf(
            "exp idx=%0d lo=%0d hi=%0d done=%b short=%b, got idx=%0d lo=%0d hi=%0d done=%b short=%b",
            want.idx, want.lo, want.hi, want.done, want.is_short,
            out_index, out_low_band, out_high_band, out_row_done, out_short_row));
        end
      end
    end
  end

  // rows of one and two samples give a single flagged result
  task automatic test_short_rows();
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
  endtask

  // rows of three to six samples: both edges mirrored, odd and even ends,
  // alternating extremes so the 16-bit sums wrap
  task automatic test_edge_rows();
    for (int len = 3; len <= 6; len++) begin
      for (int k = 0; k < len; k++) begin
        send_sample(((k + len) % 2 != 0) ? -16'sd32768 : 16'sd32767, k == len - 1);
      end
    end
  endtask

  task automatic test_random_rows(int idle, int stall, int budget);
    int sent, len, r;
    logic signed [SMP_W-1:0] s;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 8) len = $urandom_range(1, 2);
      else if (r < 85) len = $urandom_range(3, 16);
      else len = $urandom_range(17, 80);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(7))
          0:       s = 16'sd32767;
          1:       s = -16'sd32768;
          2:       s = SMP_W'(int'($urandom_range(15)) - 8);
          default: s = SMP_W'($urandom);
        endcase
        send_sample(s, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) row_win[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_short_rows();
    test_edge_rows();
    test_random_rows(0, 0, 225);
    test_random_rows(46, 0, 225);
    test_random_rows(0, 46, 225);
    test_random_rows(24, 24, 225);
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && band_q.size() != 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0 && band_q.size() == 0) begin
      $display("** subband_row_analysis_top: PASSED **");
    end else begin
      $display("** subband_row_analysis_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** subband_row_analysis_top: FAILED **");
    $finish;
  end

endmodule

[sim.f]
design/sra_pkg.sv
design/sra_front.sv
design/sra_fifo.sv
design/sra_back.sv
design/subband_row_analysis_top.sv
sim/tb_subband_row_analysis_top.sv
